/* rtl/ffha_pkg.sv */
// Shared codes and fixed field widths of the first-fit heap allocator.
// Depends on nothing; the top level and its checker import it.
`timescale 1ns / 1ps

package ffha_pkg;

	localparam int REQ_W    = 21;
	localparam int ADDR_W   = 20;
	localparam int STATUS_W = 2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_WALK,
		S_SPLIT1,
		S_SPLIT2,
		S_SPLIT3,
		S_F_A,
		S_F_AA,
		S_F_RDB,
		S_F_B,
		S_F_CA,
		S_F_WC
	} state_t;

endpackage

/* rtl/first_fit_heap_allocator.sv */
// First-fit heap allocator: chunk list in a slot memory, spare slots in a stack memory.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; its single result beat appears
// with done high for one cycle and cannot be held off. Each command walks the chunk list
// from the chunk at offset 0, one read of the slot memory per chunk visited; an allocate
// may then split the chosen chunk, and a free may merge the chunk with its free neighbors.
// After reset the block sweeps the spare slot stack, one entry per cycle, with busy high.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = 1048576,
	parameter int PAGE_BYTES   = 1024,
	parameter int HEADER_BYTES = 24,
	parameter int MAX_CHUNKS   = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cmd,
	input  logic [ffha_pkg::REQ_W-1:0]     req_size,
	input  logic [ffha_pkg::ADDR_W-1:0]    payload_addr,
	output logic                           done,
	output logic [ffha_pkg::STATUS_W-1:0]  status,
	output logic [ffha_pkg::ADDR_W-1:0]    granted_addr
);
	import ffha_pkg::*;

	localparam int SLOT_W  = $clog2(MAX_CHUNKS);
	localparam int LINK_W  = SLOT_W + 1;
	localparam int OFF_W   = $clog2(HEAP_BYTES);
	localparam int BYTES_W = $clog2(HEAP_BYTES + 1);
	localparam int PG_SH   = $clog2(PAGE_BYTES);
	localparam int SIZE_W  = REQ_W + 1;
	localparam int CMP_W   = (BYTES_W > SIZE_W) ? BYTES_W : SIZE_W;
	localparam int GA_W    = (OFF_W + 1 > ADDR_W) ? OFF_W + 1 : ADDR_W;
	localparam logic [LINK_W-1:0]  NULL_LINK = LINK_W'(MAX_CHUNKS);
	localparam logic [CMP_W-1:0]   HDR_C     = CMP_W'(HEADER_BYTES);

	typedef struct packed {
		logic [OFF_W-1:0]   off;
		logic [BYTES_W-1:0] bytes;
		logic               used;
		logic [LINK_W-1:0]  after;
		logic [LINK_W-1:0]  prev;
	} rec_t;

	rec_t              rec_mem [MAX_CHUNKS];
	logic [SLOT_W-1:0] stk_mem [MAX_CHUNKS];

	state_t              state_q, state_d;
	logic [SLOT_W-1:0]   cur_q, cur_d;
	logic                cmd_q;
	logic [SIZE_W-1:0]   size_q;
	logic [ADDR_W-1:0]   addr_q;
	rec_t                c_q, c_d;
	logic [SLOT_W-1:0]   t_q, t_d;
	logic [LINK_W-1:0]   cnt_q, cnt_d;
	logic [SLOT_W-1:0]   init_q;
	rec_t                rdata_q;
	logic [SLOT_W-1:0]   srdata_q;
	logic                done_q, done_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [ADDR_W-1:0]   gaddr_q, gaddr_d;

	logic [SLOT_W-1:0]   rd_addr;
	logic                we;
	logic [SLOT_W-1:0]   wa;
	rec_t                wd;
	logic                swe;
	logic [SLOT_W-1:0]   swa, swd, srd_addr;

	logic [SIZE_W-1:0]   size_in;
	logic [CMP_W-1:0]    rest;
	logic [CMP_W-1:0]    c_rest;
	logic [ADDR_W-1:0]   r_payload, c_payload;

	function automatic logic live(input logic [LINK_W-1:0] l);
		return l < NULL_LINK;
	endfunction

	assign size_in   = SIZE_W'((((SIZE_W)'(req_size)) >> PG_SH) + 1'b1) << PG_SH;
	assign rest      = CMP_W'(rdata_q.bytes) - CMP_W'(size_q);
	assign c_rest    = CMP_W'(c_q.bytes) - CMP_W'(size_q);
	assign r_payload = ADDR_W'(GA_W'(rdata_q.off) + GA_W'(HEADER_BYTES));
	assign c_payload = ADDR_W'(GA_W'(c_q.off) + GA_W'(HEADER_BYTES));

	always_ff @(posedge clk) begin
		if (we) begin
			rec_mem[wa] <= wd;
		end
		rdata_q <= rec_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (swe) begin
			stk_mem[swa] <= swd;
		end
		srdata_q <= stk_mem[srd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			cnt_q    <= LINK_W'(MAX_CHUNKS - 1);
			init_q   <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			gaddr_q  <= '0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			init_q   <= init_q + 1'b1;
			done_q   <= done_d;
			status_q <= status_d;
			gaddr_q  <= gaddr_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		c_q   <= c_d;
		t_q   <= t_d;
		if (state_q == S_IDLE && start) begin
			cmd_q  <= cmd;
			size_q <= size_in;
			addr_q <= payload_addr;
		end
	end

	always_comb begin
		state_d  = state_q;
		cur_d    = cur_q;
		c_d      = c_q;
		t_d      = t_q;
		cnt_d    = cnt_q;
		done_d   = 1'b0;
		status_d = status_q;
		gaddr_d  = gaddr_q;
		rd_addr  = cur_q;
		we       = 1'b0;
		wa       = cur_q;
		wd       = c_q;
		swe      = 1'b0;
		swa      = SLOT_W'(cnt_q);
		swd      = cur_q;
		srd_addr = SLOT_W'(cnt_q - 1'b1);

		case (state_q)
			S_INIT: begin
				swe = 1'b1;
				swa = init_q;
				swd = SLOT_W'(MAX_CHUNKS - 1) - init_q;
				if (init_q == '0) begin
					we = 1'b1;
					wa = '0;
					wd = '{off: '0, bytes: BYTES_W'(HEAP_BYTES - HEADER_BYTES), used: 1'b0,
						after: NULL_LINK, prev: NULL_LINK};
				end
				if (init_q == SLOT_W'(MAX_CHUNKS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				rd_addr = '0;
				if (start) begin
					cur_d   = '0;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (cmd_q == CMD_ALLOC) begin
					if (!rdata_q.used && CMP_W'(rdata_q.bytes) >= CMP_W'(size_q)) begin
						c_d = rdata_q;
						if (rest >= HDR_C && cnt_q != '0) begin
							srd_addr = SLOT_W'(cnt_q - 1'b1);
							cnt_d    = cnt_q - 1'b1;
							state_d  = S_SPLIT1;
						end else begin
							we       = 1'b1;
							wd       = rdata_q;
							wd.used  = 1'b1;
							done_d   = 1'b1;
							status_d = ST_OK;
							gaddr_d  = r_payload;
							state_d  = S_IDLE;
						end
					end else if (live(rdata_q.after)) begin
						cur_d   = rdata_q.after[SLOT_W-1:0];
						rd_addr = rdata_q.after[SLOT_W-1:0];
					end else begin
						done_d   = 1'b1;
						status_d = ST_NO_FIT;
						gaddr_d  = '0;
						state_d  = S_IDLE;
					end
				end else begin
					if (rdata_q.used && r_payload == addr_q) begin
						c_d      = rdata_q;
						c_d.used = 1'b0;
						rd_addr  = rdata_q.after[SLOT_W-1:0];
						state_d  = S_F_A;
					end else if (live(rdata_q.after)) begin
						cur_d   = rdata_q.after[SLOT_W-1:0];
						rd_addr = rdata_q.after[SLOT_W-1:0];
					end else begin
						done_d   = 1'b1;
						status_d = ST_BAD_ADDR;
						gaddr_d  = '0;
						state_d  = S_IDLE;
					end
				end
			end
			// The popped slot holds the remainder; it sits between the granted chunk
			// and its old successor.
			S_SPLIT1: begin
				t_d     = srdata_q;
				we      = 1'b1;
				wa      = srdata_q;
				wd      = '{off: OFF_W'(CMP_W'(c_q.off) + HDR_C + CMP_W'(size_q)),
					bytes: BYTES_W'(c_rest - HDR_C), used: 1'b0,
					after: c_q.after, prev: LINK_W'(cur_q)};
				rd_addr = c_q.after[SLOT_W-1:0];
				state_d = S_SPLIT2;
			end
			S_SPLIT2: begin
				if (live(c_q.after)) begin
					we      = 1'b1;
					wa      = c_q.after[SLOT_W-1:0];
					wd      = rdata_q;
					wd.prev = LINK_W'(t_q);
				end
				state_d = S_SPLIT3;
			end
			S_SPLIT3: begin
				we       = 1'b1;
				wd       = c_q;
				wd.bytes = BYTES_W'(size_q);
				wd.used  = 1'b1;
				wd.after = LINK_W'(t_q);
				done_d   = 1'b1;
				status_d = ST_OK;
				gaddr_d  = c_payload;
				state_d  = S_IDLE;
			end
			S_F_A: begin
				state_d = S_F_RDB;
				if (live(c_q.after) && !rdata_q.used) begin
					c_d.bytes = BYTES_W'(CMP_W'(c_q.bytes) + CMP_W'(rdata_q.bytes) + HDR_C);
					c_d.after = rdata_q.after;
					if (cnt_q < LINK_W'(MAX_CHUNKS)) begin
						swe   = 1'b1;
						swd   = c_q.after[SLOT_W-1:0];
						cnt_d = cnt_q + 1'b1;
					end
					if (live(rdata_q.after)) begin
						rd_addr = rdata_q.after[SLOT_W-1:0];
						state_d = S_F_AA;
					end
				end
			end
			S_F_AA: begin
				we      = 1'b1;
				wa      = c_q.after[SLOT_W-1:0];
				wd      = rdata_q;
				wd.prev = LINK_W'(cur_q);
				state_d = S_F_RDB;
			end
			S_F_RDB: begin
				rd_addr = c_q.prev[SLOT_W-1:0];
				state_d = live(c_q.prev) ? S_F_B : S_F_WC;
			end
			S_F_B: begin
				if (!rdata_q.used) begin
					we       = 1'b1;
					wa       = c_q.prev[SLOT_W-1:0];
					wd       = rdata_q;
					wd.bytes = BYTES_W'(CMP_W'(rdata_q.bytes) + CMP_W'(c_q.bytes) + HDR_C);
					wd.after = c_q.after;
					if (cnt_q < LINK_W'(MAX_CHUNKS)) begin
						swe   = 1'b1;
						swd   = cur_q;
						cnt_d = cnt_q + 1'b1;
					end
					if (live(c_q.after)) begin
						rd_addr = c_q.after[SLOT_W-1:0];
						state_d = S_F_CA;
					end else begin
						done_d   = 1'b1;
						status_d = ST_OK;
						gaddr_d  = '0;
						state_d  = S_IDLE;
					end
				end else begin
					state_d = S_F_WC;
				end
			end
			S_F_CA: begin
				we       = 1'b1;
				wa       = c_q.after[SLOT_W-1:0];
				wd       = rdata_q;
				wd.prev  = c_q.prev;
				done_d   = 1'b1;
				status_d = ST_OK;
				gaddr_d  = '0;
				state_d  = S_IDLE;
			end
			S_F_WC: begin
				we       = 1'b1;
				wd       = c_q;
				done_d   = 1'b1;
				status_d = ST_OK;
				gaddr_d  = '0;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign granted_addr = gaddr_q;

endmodule

/* rtl/ffha_checker.sv */
// Port-level checks of the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [ffha_pkg::STATUS_W-1:0]  status,
	input logic [ffha_pkg::ADDR_W-1:0]    granted_addr
);
	import ffha_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted command did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("two result beats in a row");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_NO_FIT || status == ST_BAD_ADDR))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> granted_addr == '0)
		else $error("failed command returned an address");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .granted_addr(granted_addr)
);

/* tb/tb_first_fit_heap_allocator.sv */
// Self-checking bench for first_fit_heap_allocator: directed and random allocate/free beats,
// checked against a chunk-list model of the heap kept inside the bench.
// Depends on ffha_pkg and rtl/first_fit_heap_allocator.sv.
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	localparam int HEAP  = 1048576;
	localparam int PAGE  = 1024;
	localparam int HDR   = 24;
	localparam int SLOTS = 1024;
	localparam int NONE  = SLOTS;

	typedef struct {
		logic              op;
		logic [REQ_W-1:0]  req;
		logic [ADDR_W-1:0] addr;
		int                gap;
		bit                drain;
	} cmd_beat_t;

	typedef struct {
		logic [STATUS_W-1:0] st;
		logic [ADDR_W-1:0]   grant;
	} reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                cmd = CMD_ALLOC;
	logic [REQ_W-1:0]    req_size = '0;
	logic [ADDR_W-1:0]   payload_addr = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   granted_addr;

	first_fit_heap_allocator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.req_size(req_size), .payload_addr(payload_addr), .done(done),
		.status(status), .granted_addr(granted_addr)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Heap model: chunk slots linked in address order, plus a stack of unused slots.
	logic [ADDR_W-1:0] hp_ofs[SLOTS];
	logic [20:0]       hp_len[SLOTS];
	bit                hp_used[SLOTS];
	logic [10:0]       hp_next[SLOTS];
	logic [10:0]       hp_prev[SLOTS];
	logic [9:0]        hp_pool[SLOTS];
	int unsigned       hp_pool_n;

	cmd_beat_t         pending[$];
	reply_t            expected_replies[$];
	logic [ADDR_W-1:0] held[$];
	logic [ADDR_W-1:0] released[$];
	int                errors = 0;
	int                loaded = 0;
	int                taken = 0;
	int                outstanding = 0;
	int                hold = 0;

	function automatic void heap_reset();
		for (int i = 0; i < SLOTS; i++) begin
			hp_ofs[i] = '0;
			hp_len[i] = '0;
			hp_used[i] = 1'b0;
			hp_next[i] = 11'(NONE);
			hp_prev[i] = 11'(NONE);
			hp_pool[i] = '0;
		end
		hp_len[0] = 21'(HEAP - HDR);
		for (int i = 0; i + 1 < SLOTS; i++)
			hp_pool[i] = 10'(SLOTS - 1 - i);
		hp_pool_n = SLOTS - 1;
	endfunction

	function automatic void unlink_slot(int s);
		int a;
		int b;
		a = hp_next[s];
		b = hp_prev[s];
		if (b < SLOTS) hp_next[b] = 11'(a);
		if (a < SLOTS) hp_prev[a] = 11'(b);
		hp_used[s] = 1'b0;
		if (hp_pool_n < SLOTS) begin
			hp_pool[hp_pool_n] = 10'(s);
			hp_pool_n++;
		end
	endfunction

	function automatic reply_t heap_alloc(logic [REQ_W-1:0] req);
		reply_t r;
		int unsigned want;
		int unsigned rest;
		int s;
		int t;
		int a;
		want = (int'(req) / PAGE + 1) * PAGE;
		r.st = ST_NO_FIT;
		r.grant = '0;
		s = 0;
		for (int n = 0; n < SLOTS && s < SLOTS; n++) begin
			if (!hp_used[s] && hp_len[s] >= want) begin
				rest = hp_len[s] - want;
				if (rest >= HDR && hp_pool_n > 0) begin
					a = hp_next[s];
					hp_pool_n--;
					t = hp_pool[hp_pool_n];
					hp_ofs[t] = hp_ofs[s] + ADDR_W'(HDR) + ADDR_W'(want);
					hp_len[t] = 21'(rest - HDR);
					hp_used[t] = 1'b0;
					hp_prev[t] = 11'(s);
					hp_next[t] = 11'(a);
					if (a < SLOTS) hp_prev[a] = 11'(t);
					hp_next[s] = 11'(t);
					hp_len[s] = 21'(want);
				end
				hp_used[s] = 1'b1;
				r.st = ST_OK;
				r.grant = hp_ofs[s] + ADDR_W'(HDR);
				return r;
			end
			s = hp_next[s];
		end
		return r;
	endfunction

	function automatic reply_t heap_free(logic [ADDR_W-1:0] addr);
		reply_t r;
		int s;
		int a;
		int b;
		r.st = ST_BAD_ADDR;
		r.grant = '0;
		s = 0;
		for (int n = 0; n < SLOTS && s < SLOTS; n++) begin
			if (hp_used[s] && hp_ofs[s] + ADDR_W'(HDR) == addr) begin
				a = hp_next[s];
				b = hp_prev[s];
				hp_used[s] = 1'b0;
				if (a < SLOTS && !hp_used[a]) begin
					hp_len[s] = hp_len[s] + hp_len[a] + 21'(HDR);
					unlink_slot(a);
				end
				if (b < SLOTS && !hp_used[b]) begin
					hp_len[b] = hp_len[b] + hp_len[s] + 21'(HDR);
					unlink_slot(s);
				end
				r.st = ST_OK;
				return r;
			end
			s = hp_next[s];
		end
		return r;
	endfunction

	// Queues one command beat and the reply the heap model predicts for it.
	task automatic queue_beat(logic op, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr,
			bit drain);
		cmd_beat_t c;
		reply_t r;
		int k;
		int idx[$];
		c.op = op;
		c.req = req;
		c.addr = addr;
		c.drain = drain;
		k = $urandom_range(0, 99);
		c.gap = (k < 65) ? 0 : (k < 93) ? $urandom_range(1, 3) : $urandom_range(10, 150);
		if (op == CMD_FREE) begin
			r = heap_free(addr);
			if (r.st == ST_OK) begin
				idx = held.find_first_index(x) with (x == addr);
				if (idx.size() > 0) held.delete(idx[0]);
				released.push_back(addr);
			end
		end else begin
			r = heap_alloc(req);
			if (r.st == ST_OK) held.push_back(r.grant);
		end
		pending.push_back(c);
		expected_replies.push_back(r);
	endtask

	function automatic logic [REQ_W-1:0] pick_size();
		int k;
		k = $urandom_range(0, 99);
		if (k < 70) return REQ_W'($urandom_range(0, 4095));
		if (k < 90) return REQ_W'($urandom_range(4096, 65535));
		if (k < 96) return REQ_W'($urandom_range(65536, HEAP));
		return REQ_W'($urandom);
	endfunction

	function automatic logic [ADDR_W-1:0] take_held();
		return held[$urandom_range(0, held.size() - 1)];
	endfunction

	// Monitor: count accepted beats and check every result beat.
	always @(posedge clk) begin
		reply_t e;
		if (arst_n) begin
			if (done) begin
				if (outstanding == 0 || expected_replies.size() == 0) begin
					$display("%0t: result beat with nothing outstanding, status %0d addr %0h",
						$time, status, granted_addr);
					errors++;
				end else begin
					e = expected_replies.pop_front();
					outstanding--;
					if (status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time, e.st, status);
						errors++;
					end
					if (granted_addr !== e.grant) begin
						$display("%0t: granted_addr expected %0h actual %0h",
							$time, e.grant, granted_addr);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				taken++;
				outstanding++;
			end
		end
	end

	// Driver: present beats from the pending queue with random gaps between them.
	always @(negedge clk) begin
		cmd_beat_t c;
		if (arst_n && (!start || taken == loaded)) begin
			if (start && pending.size() > 0) hold = pending[0].gap;
			if (hold > 0) begin
				hold--;
				start <= 1'b0;
			end else if (pending.size() > 0 && !(pending[0].drain && outstanding != 0)) begin
				c = pending.pop_front();
				cmd <= c.op;
				req_size <= c.req;
				payload_addr <= c.addr;
				start <= 1'b1;
				loaded++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	initial begin
		logic [ADDR_W-1:0] a0;
		logic [ADDR_W-1:0] a1;
		logic [ADDR_W-1:0] a2;
		int k;
		heap_reset();
		// Two adjacent frees merge into one chunk of 2048 + header; taking 2048 back out
		// leaves exactly one header, which splits off a free chunk of zero bytes.
		queue_beat(CMD_ALLOC, '0, '1, 1'b0);
		a0 = held[$];
		queue_beat(CMD_ALLOC, 21'd1023, '0, 1'b0);
		a1 = held[$];
		queue_beat(CMD_ALLOC, 21'd1024, '0, 1'b0);
		a2 = held[$];
		queue_beat(CMD_FREE, '1, a0, 1'b0);
		queue_beat(CMD_FREE, '0, a1, 1'b0);
		queue_beat(CMD_ALLOC, 21'd2047, '0, 1'b0);
		queue_beat(CMD_ALLOC, 21'd2047, '0, 1'b0);
		queue_beat(CMD_FREE, '0, a0, 1'b0);
		queue_beat(CMD_FREE, '0, a0, 1'b0);
		queue_beat(CMD_FREE, '0, '0, 1'b0);
		queue_beat(CMD_FREE, '0, '1, 1'b0);
		queue_beat(CMD_ALLOC, 21'(HEAP), '0, 1'b0);
		queue_beat(CMD_ALLOC, '1, '0, 1'b0);
		queue_beat(CMD_ALLOC, 21'(HEAP - HDR - PAGE * 8), '1, 1'b0);
		// A freed chunk merges into its free previous neighbor; the next allocate splits off the merged chunk.
		queue_beat(CMD_FREE, '1, a2, 1'b0);
		queue_beat(CMD_ALLOC, 21'd1024, '0, 1'b0);
		queue_beat(CMD_FREE, '0, held[0], 1'b1);
		for (int i = 0; i < 1600; i++) begin
			k = $urandom_range(0, 99);
			if (k < 52 || (k < 92 && held.size() == 0))
				queue_beat(CMD_ALLOC, pick_size(), ADDR_W'($urandom), i % 400 == 399);
			else if (k < 92)
				queue_beat(CMD_FREE, REQ_W'($urandom), take_held(), i % 400 == 399);
			else if (k < 96 && released.size() > 0)
				queue_beat(CMD_FREE, REQ_W'($urandom),
					released[$urandom_range(0, released.size() - 1)], 1'b0);
			else
				queue_beat(CMD_FREE, REQ_W'($urandom), ADDR_W'($urandom), 1'b0);
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending.size() == 0 && taken == loaded && outstanding == 0);
		repeat (64) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_replies.size());
			errors++;
		end
		if (errors == 0)
			$display("first_fit_heap_allocator verification clean");
		else
			$display("first_fit_heap_allocator verification failed");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("first_fit_heap_allocator verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/ffha_pkg.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
tb/tb_first_fit_heap_allocator.sv
